// ----- src/daily_and_interval_event_table_assert.svh -----
// ----------------------------------------------------------------------------
// Event table assertion macros
// Concurrent assertion wrappers used by the verification checker.
// ----------------------------------------------------------------------------
`ifndef DAILY_AND_INTERVAL_EVENT_TABLE_ASSERT_SVH
`define DAILY_AND_INTERVAL_EVENT_TABLE_ASSERT_SVH

// check prop at every clock edge outside reset
`define DAET_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check prop at every clock edge, reset included
`define DAET_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/daet_pkg.sv -----
// ----------------------------------------------------------------------------
// Event table package
// Shared codes, entry layout and digit decoding for the event table.
// ----------------------------------------------------------------------------
`default_nettype none

package daet_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;

   localparam int VAL_W   = 7;
   localparam int TOTAL_W = 13;
   localparam int SPAN_W  = 19;
   localparam int SEC_W   = 32;

   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_NO_TIME = 3'd2;
   localparam logic [2:0] ST_NONE    = 3'd3;
   localparam logic [2:0] ST_FIRED   = 3'd4;

   localparam logic [1:0] KIND_INERT  = 2'd0;
   localparam logic [1:0] KIND_DAILY  = 2'd1;
   localparam logic [1:0] KIND_REPEAT = 2'd2;

   localparam logic [7:0] CHAR_DAILY  = 8'h64;
   localparam logic [7:0] CHAR_REPEAT = 8'h72;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   typedef struct packed {
      logic [7:0]         id;
      logic [1:0]         kind;
      logic [VAL_W-1:0]   hour;
      logic [VAL_W-1:0]   minute;
      logic [SPAN_W-1:0]  span;
   } entry_type;

   typedef struct packed {
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [SEC_W-1:0]  seconds;
   } now_type;

   function automatic logic [VAL_W-1:0] decode_pair(input logic [5:0] tens,
                                                     input logic [5:0] ones);
      logic [VAL_W-1:0] t;
      logic [VAL_W-1:0] o;
      t = VAL_W'({2'b00, tens} - CHAR_ZERO);
      o = VAL_W'({2'b00, ones} - CHAR_ZERO);
      decode_pair = (t << 3) + (t << 1) + o;
   endfunction

endpackage

`default_nettype wire

// ----- src/daet_channels.sv -----
// ----------------------------------------------------------------------------
// Event table channels
// Request and response handshake interfaces of the event table.
// ----------------------------------------------------------------------------
`default_nettype none

interface daet_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] event_id;
   logic [7:0] type_char;
   logic [5:0] hour_tens_char;
   logic [5:0] hour_ones_char;
   logic [5:0] minute_tens_char;
   logic [5:0] minute_ones_char;
   logic       time_valid;
   logic [4:0] now_hour;
   logic [5:0] now_minute;
   logic [31:0] now_seconds;

   modport source (output valid, mode, event_id, type_char, hour_tens_char,
                   hour_ones_char, minute_tens_char, minute_ones_char,
                   time_valid, now_hour, now_minute, now_seconds,
                   input ready);
   modport sink (input valid, mode, event_id, type_char, hour_tens_char,
                 hour_ones_char, minute_tens_char, minute_ones_char,
                 time_valid, now_hour, now_minute, now_seconds,
                 output ready);
endinterface

interface daet_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] fired_id;

   modport source (output valid, status, fired_id, input ready);
   modport sink (input valid, status, fired_id, output ready);
endinterface

`default_nettype wire

// ----- src/daily_and_interval_event_table.sv -----
// ----------------------------------------------------------------------------
// Daily and interval event table
// Stores scheduled events and reports the first one due at a time check.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one item per handshake: mode 0 adds an event from its id,
//   type character and four ASCII digits; mode 1 checks the table against
//   now_hour, now_minute and now_seconds. rsp_if returns one item per request
//   with a status code and the id of the entry that fired.
//   An add runs through decode, minute total, span in seconds with table
//   write, and output load (only decode and output load when it is refused),
//   all on one small shift-add datapath.
//   A check reads the table memory one entry a cycle, and the single match
//   unit evaluates each entry in the cycle after its read; the scan stops at
//   the first entry that fires, or after the last stored entry.
//   req_if.ready is high only while no item is in work, so the next item can
//   be accepted in the same cycle that a response appears; a finished response sits in
//   the output register, so the next item is accepted while rsp_if is
//   stalled, and it waits before its own response until that one leaves.
//   Reset empties the table (entry count zero) and drops any pending
//   response; table contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module daily_and_interval_event_table #(
   parameter int MAX_ENTRIES = daet_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   daet_req_if.sink   req_if,
   daet_rsp_if.source rsp_if
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_ENTRIES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_TOTAL  = 3'd2;
   localparam logic [2:0] S_SPAN   = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;

   logic [7:0]       id_ff, id_in;
   logic [7:0]       type_ff, type_in;
   logic [5:0]       ht_ff, ht_in, ho_ff, ho_in, mt_ff, mt_in, mo_ff, mo_in;
   logic             tvalid_ff, tvalid_in;
   daet_pkg::now_type now_ff, now_in;

   logic [1:0]                    kind_ff, kind_in;
   logic [daet_pkg::VAL_W-1:0]    hour_ff, hour_in, minute_ff, minute_in;
   logic [daet_pkg::TOTAL_W-1:0]  total_ff, total_in;

   logic [2:0] res_status_ff, res_status_in;
   logic [7:0] res_fired_ff, res_fired_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_fired_ff, rsp_fired_in;

   daet_pkg::entry_type entry_mem [MAX_ENTRIES];
   logic [daet_pkg::SEC_W-1:0] last_mem [MAX_ENTRIES];

   daet_pkg::entry_type        rd_entry_ff;
   logic [daet_pkg::SEC_W-1:0] rd_last_ff;

   logic                       rd_en;
   logic                       ent_we;
   daet_pkg::entry_type        ent_wdata;
   logic                       last_we;
   logic [IDX_W-1:0]           last_waddr;
   logic [daet_pkg::SEC_W-1:0] last_wdata;
   logic                       accept;
   logic                       hit;
   logic [daet_pkg::SPAN_W-1:0] span;

   daet_match u_match (
      .entry     (rd_entry_ff),
      .last_fire (rd_last_ff),
      .now       (now_ff),
      .hit       (hit)
   );

   assign req_if.ready    = (state_ff == S_IDLE);
   assign accept          = req_if.valid && req_if.ready;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.fired_id = rsp_fired_ff;

   assign span = {total_ff, 6'b000000} - daet_pkg::SPAN_W'({total_ff, 2'b00});

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      id_in         = id_ff;
      type_in       = type_ff;
      ht_in         = ht_ff;
      ho_in         = ho_ff;
      mt_in         = mt_ff;
      mo_in         = mo_ff;
      tvalid_in     = tvalid_ff;
      now_in        = now_ff;
      kind_in       = kind_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      total_in      = total_ff;
      res_status_in = res_status_ff;
      res_fired_in  = res_fired_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rd_en         = 1'b0;
      ent_we        = 1'b0;
      ent_wdata     = '{id: id_ff, kind: kind_ff, hour: hour_ff, minute: minute_ff,
                        span: span};
      last_we       = 1'b0;
      last_waddr    = count_ff[IDX_W-1:0];
      last_wdata    = now_ff.seconds;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               id_in     = req_if.event_id;
               type_in   = req_if.type_char;
               ht_in     = req_if.hour_tens_char;
               ho_in     = req_if.hour_ones_char;
               mt_in     = req_if.minute_tens_char;
               mo_in     = req_if.minute_ones_char;
               tvalid_in = req_if.time_valid;
               now_in    = '{hour: req_if.now_hour, minute: req_if.now_minute,
                             seconds: req_if.now_seconds};
               ptr_in    = '0;
               pend_in   = 1'b0;
               state_in  = req_if.mode ? S_SCAN : S_DECODE;
            end
         end
         S_DECODE: begin
            res_fired_in = 8'd0;
            if (count_ff >= COUNT_MAX) begin
               res_status_in = daet_pkg::ST_FULL;
               state_in      = S_FINISH;
            end else if (type_ff == daet_pkg::CHAR_REPEAT && !tvalid_ff) begin
               res_status_in = daet_pkg::ST_NO_TIME;
               state_in      = S_FINISH;
            end else begin
               hour_in   = daet_pkg::decode_pair(ht_ff, ho_ff);
               minute_in = daet_pkg::decode_pair(mt_ff, mo_ff);
               if (type_ff == daet_pkg::CHAR_DAILY) begin
                  kind_in = daet_pkg::KIND_DAILY;
               end else if (type_ff == daet_pkg::CHAR_REPEAT) begin
                  kind_in = daet_pkg::KIND_REPEAT;
               end else begin
                  kind_in = daet_pkg::KIND_INERT;
               end
               state_in = S_TOTAL;
            end
         end
         S_TOTAL: begin
            total_in = {hour_ff, 6'b000000} - daet_pkg::TOTAL_W'({hour_ff, 2'b00})
                       + daet_pkg::TOTAL_W'(minute_ff);
            state_in = S_SPAN;
         end
         S_SPAN: begin
            ent_we        = 1'b1;
            last_we       = (kind_ff == daet_pkg::KIND_REPEAT);
            count_in      = count_ff + 1'b1;
            res_status_in = daet_pkg::ST_ADDED;
            state_in      = S_FINISH;
         end
         S_SCAN: begin
            if (pend_ff && hit) begin
               last_we       = (rd_entry_ff.kind == daet_pkg::KIND_REPEAT);
               last_waddr    = pend_idx_ff;
               res_status_in = daet_pkg::ST_FIRED;
               res_fired_in  = rd_entry_ff.id;
               pend_in       = 1'b0;
               state_in      = S_FINISH;
            end else if (ptr_ff < count_ff) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff + 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               res_status_in = daet_pkg::ST_NONE;
               res_fired_in  = 8'd0;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fired_in  = res_fired_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      id_ff         <= id_in;
      type_ff       <= type_in;
      ht_ff         <= ht_in;
      ho_ff         <= ho_in;
      mt_ff         <= mt_in;
      mo_ff         <= mo_in;
      tvalid_ff     <= tvalid_in;
      now_ff        <= now_in;
      kind_ff       <= kind_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      total_ff      <= total_in;
      res_status_ff <= res_status_in;
      res_fired_ff  <= res_fired_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[count_ff[IDX_W-1:0]] <= ent_wdata;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (last_we) begin
         last_mem[last_waddr] <= last_wdata;
      end
      if (rd_en) begin
         rd_last_ff <= last_mem[ptr_ff[IDX_W-1:0]];
      end
   end

endmodule

`default_nettype wire

// ----- src/daet_match.sv -----
// ----------------------------------------------------------------------------
// Event table match unit
// Shared compare unit: tests one stored entry against the current time.
// ----------------------------------------------------------------------------
`default_nettype none

module daet_match (
   input  daet_pkg::entry_type        entry,
   input  logic [daet_pkg::SEC_W-1:0] last_fire,
   input  daet_pkg::now_type          now,
   output logic                       hit
);

   logic [daet_pkg::SEC_W:0] diff;
   logic [daet_pkg::SEC_W:0] span_ext;
   logic                     daily_hit;
   logic                     repeat_hit;

   assign diff       = {1'b0, now.seconds} - {1'b0, last_fire};
   assign span_ext   = (daet_pkg::SEC_W + 1)'(entry.span);
   assign repeat_hit = $signed(diff) >= $signed(span_ext);
   assign daily_hit  = (entry.hour == {2'b00, now.hour}) &&
                       (entry.minute == {1'b0, now.minute});

   always_comb begin
      case (entry.kind)
         daet_pkg::KIND_DAILY:  hit = daily_hit;
         daet_pkg::KIND_REPEAT: hit = repeat_hit;
         default:               hit = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/daet_checker.sv -----
// ----------------------------------------------------------------------------
// Event table checker
// Port-level assertions on the event table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "daily_and_interval_event_table_assert.svh"

module daet_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [7:0] rsp_fired_id
);

   `DAET_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_fired_id), "stalled response item changed")

   `DAET_ASSERT(a_status_code, clock, reset, rsp_valid |-> (rsp_status == daet_pkg::ST_ADDED || rsp_status == daet_pkg::ST_FULL || rsp_status == daet_pkg::ST_NO_TIME || rsp_status == daet_pkg::ST_NONE || rsp_status == daet_pkg::ST_FIRED), "undefined status code")

   `DAET_ASSERT(a_id_zero, clock, reset, rsp_valid && rsp_status != daet_pkg::ST_FIRED |-> rsp_fired_id == 8'd0, "fired id set without a firing")

   `DAET_ASSERT(a_busy, clock, reset, req_valid && req_ready |=> !req_ready, "item accepted while previous item in work")

   `DAET_ASSERT_ALWAYS(a_reset_drop, clock, $past(reset) |-> !rsp_valid, "response item survived reset")

endmodule

bind daily_and_interval_event_table daet_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_status   (rsp_if.status),
   .rsp_fired_id (rsp_if.fired_id)
);

`default_nettype wire

// ----- sim/tb_daily_and_interval_event_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event table testbench
// Drives add and check items into the event table with random idle and stall
// bursts, predicts every response from a local copy of the table, and compares
// status and fired id of each response item against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_daily_and_interval_event_table;

   localparam int   TABLE_DEPTH = daet_pkg::MAX_ENTRIES_DEFAULT;
   localparam int   RANDOM_ITEMS = 535;
   localparam int   TAIL_ITEMS = 60;
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   typedef struct {
      logic        mode;
      logic [7:0]  event_id;
      logic [7:0]  type_char;
      logic [5:0]  hour_tens;
      logic [5:0]  hour_ones;
      logic [5:0]  minute_tens;
      logic [5:0]  minute_ones;
      logic        time_valid;
      logic [4:0]  now_hour;
      logic [5:0]  now_minute;
      logic [31:0] now_seconds;
   } sched_req_type;

   typedef struct {
      logic [2:0] status;
      logic [7:0] fired_id;
   } sched_rsp_type;

   logic clock;
   logic reset;

   daet_req_if req_ch ();
   daet_rsp_if rsp_ch ();

   daily_and_interval_event_table DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   sched_req_type request_q[$];
   sched_rsp_type outcome_q[$];
   sched_rsp_type rsp_want;

   // local copy of the event table
   logic [7:0]  tbl_id     [TABLE_DEPTH];
   logic [1:0]  tbl_kind   [TABLE_DEPTH];
   logic [6:0]  tbl_hour   [TABLE_DEPTH];
   logic [6:0]  tbl_minute [TABLE_DEPTH];
   logic [31:0] tbl_last   [TABLE_DEPTH];
   int          tbl_count = 0;

   // stimulus-side view of the table, used to aim daily checks
   int          gen_count = 0;
   logic [6:0]  aim_hour[$];
   logic [6:0]  aim_minute[$];
   logic [31:0] wall;

   int req_gap = 0;
   int rsp_gap = 0;
   int error_count = 0;
   int n_add = 0, n_full = 0, n_no_time = 0;
   int n_check = 0, n_daily_fire = 0, n_repeat_fire = 0, n_none = 0;

   function automatic logic [6:0] digit_pair(input logic [5:0] tens, input logic [5:0] ones);
      logic [7:0] t;
      logic [7:0] o;
      int         v;
      t = {2'b00, tens} - daet_pkg::CHAR_ZERO;
      o = {2'b00, ones} - daet_pkg::CHAR_ZERO;
      v = int'(t) * 10 + int'(o);
      return v[6:0];
   endfunction

   function automatic logic [5:0] ascii_digit(input int d);
      return 6'(int'(daet_pkg::CHAR_ZERO) + d);
   endfunction

   function automatic void schedule_step(input sched_req_type it);
      sched_rsp_type r;
      longint        elapsed;
      longint        span;
      logic          hit;
      int            k;
      r.status = daet_pkg::ST_NONE;
      r.fired_id = 8'd0;
      hit = 1'b0;
      if (it.mode == MODE_ADD) begin
         n_add++;
         if (tbl_count >= TABLE_DEPTH) begin
            r.status = daet_pkg::ST_FULL;
            n_full++;
         end else if (it.type_char == daet_pkg::CHAR_REPEAT && !it.time_valid) begin
            r.status = daet_pkg::ST_NO_TIME;
            n_no_time++;
         end else begin
            k = tbl_count;
            tbl_id[k] = it.event_id;
            tbl_kind[k] = (it.type_char == daet_pkg::CHAR_DAILY) ? daet_pkg::KIND_DAILY :
                          (it.type_char == daet_pkg::CHAR_REPEAT) ? daet_pkg::KIND_REPEAT :
                          daet_pkg::KIND_INERT;
            tbl_hour[k] = digit_pair(it.hour_tens, it.hour_ones);
            tbl_minute[k] = digit_pair(it.minute_tens, it.minute_ones);
            if (tbl_kind[k] == daet_pkg::KIND_REPEAT) tbl_last[k] = it.now_seconds;
            tbl_count = k + 1;
            r.status = daet_pkg::ST_ADDED;
         end
      end else begin
         n_check++;
         for (int i = 0; i < tbl_count && !hit; i++) begin
            if (tbl_kind[i] == daet_pkg::KIND_DAILY) begin
               if ({2'b00, it.now_hour} == tbl_hour[i] &&
                   {1'b0, it.now_minute} == tbl_minute[i]) begin
                  hit = 1'b1;
                  r.status = daet_pkg::ST_FIRED;
                  r.fired_id = tbl_id[i];
                  n_daily_fire++;
               end
            end else if (tbl_kind[i] == daet_pkg::KIND_REPEAT) begin
               elapsed = longint'({32'd0, it.now_seconds}) - longint'({32'd0, tbl_last[i]});
               span = (longint'(tbl_hour[i]) * 60 + longint'(tbl_minute[i])) * 60;
               if (elapsed >= span) begin
                  hit = 1'b1;
                  tbl_last[i] = it.now_seconds;
                  r.status = daet_pkg::ST_FIRED;
                  r.fired_id = tbl_id[i];
                  n_repeat_fire++;
               end
            end
         end
         if (!hit) n_none++;
      end
      outcome_q.push_back(r);
   endfunction

   task automatic queue_add(input logic [7:0] id, input logic [7:0] kind_char,
                            input logic [5:0] ht, input logic [5:0] ho,
                            input logic [5:0] mt, input logic [5:0] mo,
                            input logic tv, input logic [31:0] secs);
      sched_req_type it;
      it.mode = MODE_ADD;
      it.event_id = id;
      it.type_char = kind_char;
      it.hour_tens = ht;
      it.hour_ones = ho;
      it.minute_tens = mt;
      it.minute_ones = mo;
      it.time_valid = tv;
      it.now_hour = 5'($urandom_range(0, 31));
      it.now_minute = 6'($urandom_range(0, 63));
      it.now_seconds = secs;
      request_q.push_back(it);
      if (gen_count < TABLE_DEPTH && !(kind_char == daet_pkg::CHAR_REPEAT && !tv)) begin
         gen_count++;
         if (kind_char == daet_pkg::CHAR_DAILY) begin
            aim_hour.push_back(digit_pair(ht, ho));
            aim_minute.push_back(digit_pair(mt, mo));
         end
      end
   endtask

   task automatic queue_check(input logic [4:0] hr, input logic [5:0] mn,
                              input logic [31:0] secs);
      sched_req_type it;
      it.mode = MODE_CHECK;
      it.event_id = 8'($urandom);
      it.type_char = 8'($urandom);
      it.hour_tens = 6'($urandom_range(0, 63));
      it.hour_ones = 6'($urandom_range(0, 63));
      it.minute_tens = 6'($urandom_range(0, 63));
      it.minute_ones = 6'($urandom_range(0, 63));
      it.time_valid = 1'($urandom_range(0, 1));
      it.now_hour = hr;
      it.now_minute = mn;
      it.now_seconds = secs;
      request_q.push_back(it);
   endtask

   task automatic queue_random_add();
      logic [7:0]  kind_char;
      logic [5:0]  ht, ho, mt, mo;
      int          sel, h, m;
      sel = $urandom_range(0, 9);
      kind_char = (sel < 4) ? daet_pkg::CHAR_DAILY :
                  (sel < 8) ? daet_pkg::CHAR_REPEAT : 8'($urandom);
      if (kind_char == daet_pkg::CHAR_DAILY) begin
         h = $urandom_range(0, 23);
         m = $urandom_range(0, 59);
      end else begin
         h = ($urandom_range(0, 9) == 0) ? 1 : 0;
         m = $urandom_range(1, 8);
      end
      ht = ascii_digit(h / 10);
      ho = ascii_digit(h % 10);
      mt = ascii_digit(m / 10);
      mo = ascii_digit(m % 10);
      if ($urandom_range(0, 7) == 0) begin
         ht = 6'($urandom_range(0, 63));
         ho = 6'($urandom_range(0, 63));
         mt = 6'($urandom_range(0, 63));
         mo = 6'($urandom_range(0, 63));
      end
      queue_add(8'($urandom), kind_char, ht, ho, mt, mo,
                1'($urandom_range(0, 5) != 0), wall);
   endtask

   task automatic queue_random_check();
      logic [31:0] secs;
      logic [31:0] jump;
      logic [4:0]  hr;
      logic [5:0]  mn;
      int          sel, pick;
      wall = wall + 32'($urandom_range(0, 300));
      sel = $urandom_range(0, 24);
      secs = wall;
      if (sel < 3) begin
         secs = wall - 32'($urandom_range(1, 2000));
      end else if (sel == 3) begin
         jump = $urandom;
         if (jump > wall && jump < 32'hF000_0000) wall = jump;
         secs = jump;
      end
      if (aim_hour.size() != 0 && $urandom_range(0, 9) < 6) begin
         pick = $urandom_range(0, aim_hour.size() - 1);
         hr = aim_hour[pick][4:0];
         mn = aim_minute[pick][5:0];
      end else if ($urandom_range(0, 9) == 0) begin
         hr = 5'($urandom_range(0, 31));
         mn = 6'($urandom_range(0, 63));
      end else begin
         hr = 5'($urandom_range(0, 23));
         mn = 6'($urandom_range(0, 59));
      end
      queue_check(hr, mn, secs);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $error("timeout with %0d items unsent and %0d responses outstanding",
             request_q.size(), outcome_q.size());
      $display("Test completed with failures");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            schedule_step(request_q.pop_front());
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the item until it is taken
         end else if (request_q.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(0, 11);
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid <= 1'b1;
            req_ch.mode <= request_q[0].mode;
            req_ch.event_id <= request_q[0].event_id;
            req_ch.type_char <= request_q[0].type_char;
            req_ch.hour_tens_char <= request_q[0].hour_tens;
            req_ch.hour_ones_char <= request_q[0].hour_ones;
            req_ch.minute_tens_char <= request_q[0].minute_tens;
            req_ch.minute_ones_char <= request_q[0].minute_ones;
            req_ch.time_valid <= request_q[0].time_valid;
            req_ch.now_hour <= request_q[0].now_hour;
            req_ch.now_minute <= request_q[0].now_minute;
            req_ch.now_seconds <= request_q[0].now_seconds;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
               $error("unexpected response item: status %0d fired_id %0d",
                      rsp_ch.status, rsp_ch.fired_id);
               error_count++;
            end else begin
               rsp_want = outcome_q.pop_front();
               if (rsp_ch.status !== rsp_want.status) begin
                  $error("status: expected %0d, got %0d", rsp_want.status, rsp_ch.status);
                  error_count++;
               end
               if (rsp_ch.fired_id !== rsp_want.fired_id) begin
                  $error("fired_id: expected %0d, got %0d", rsp_want.fired_id,
                         rsp_ch.fired_id);
                  error_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 11);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_ADD;
      req_ch.event_id = 8'd0;
      req_ch.type_char = 8'd0;
      req_ch.hour_tens_char = 6'd0;
      req_ch.hour_ones_char = 6'd0;
      req_ch.minute_tens_char = 6'd0;
      req_ch.minute_ones_char = 6'd0;
      req_ch.time_valid = 1'b0;
      req_ch.now_hour = 5'd0;
      req_ch.now_minute = 6'd0;
      req_ch.now_seconds = 32'd0;
      rsp_ch.ready = 1'b0;

      // directed: empty table, refusals, odd characters, extremes of time
      queue_check(5'd0, 6'd0, 32'd0);
      queue_add(8'h33, daet_pkg::CHAR_REPEAT, ascii_digit(0), ascii_digit(0),
                ascii_digit(0), ascii_digit(1), 1'b0, 32'h1234_5678);
      queue_add(8'h00, daet_pkg::CHAR_DAILY, ascii_digit(2), ascii_digit(3),
                ascii_digit(5), ascii_digit(9), 1'b0, 32'd0);
      queue_add(8'hFF, daet_pkg::CHAR_REPEAT, ascii_digit(9), ascii_digit(9),
                ascii_digit(9), ascii_digit(9), 1'b1, 32'h8000_0000);
      queue_add(8'h7E, 8'hFF, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 1'b1, 32'hFFFF_FFFF);
      queue_add(8'h5A, daet_pkg::CHAR_DAILY, ascii_digit(0), 6'h3A, ascii_digit(5), 6'h3B,
                1'b1, 32'd0);
      queue_add(8'h11, daet_pkg::CHAR_REPEAT, ascii_digit(0), ascii_digit(0),
                ascii_digit(0), ascii_digit(0), 1'b1, 32'hFFFF_FFFF);
      queue_add(8'h22, 8'h00, 6'h00, 6'h00, 6'h00, 6'h00, 1'b0, 32'd0);
      queue_check(5'd23, 6'd59, 32'd0);
      queue_check(5'd10, 6'd61, 32'h8000_0000 + 32'd362339);
      queue_check(5'd0, 6'd0, 32'h8000_0000 + 32'd362340);
      queue_check(5'd0, 6'd0, 32'h8000_0000 + 32'd362340);
      queue_check(5'd31, 6'd63, 32'hFFFF_FFFF);
      queue_check(5'd31, 6'd63, 32'hFFFF_FFFF);
      queue_check(5'd23, 6'd59, 32'hFFFF_FFFF);

      wall = $urandom_range(32'h1000_0000, 32'h7000_0000);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 15) queue_random_add();
         else queue_random_check();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || outcome_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Ran %0d adds (%0d refused on a full table, %0d refused without time)",
               n_add, n_full, n_no_time);
      $display("and %0d checks: %0d daily and %0d repeating fired, %0d found nothing due.",
               n_check, n_daily_fire, n_repeat_fire, n_none);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
